// ----- hdl/uis_pkg.sv -----
`timescale 1ns / 1ps
package uis_pkg;
   localparam int MaxEntries = 64;
   localparam int IdxW = $clog2(MaxEntries);
   localparam int CntW = $clog2(MaxEntries + 1);
   localparam logic [31:0] UidAllOnes = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_QUERY = 2'd1,
      OP_LOWER = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NO_LOWER = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MOVE,
      S_WRITE,
      S_SUM,
      S_DONE
   } state_type;
endpackage

// ----- hdl/uid_interval_set.sv -----
`timescale 1ns / 1ps
// Sorted, merged set of 32-bit ID intervals kept in one 64-entry memory with
// a synchronous read. A query, a next-lower above zero and an accepted add
// with a nonzero count make one pass over the stored entries (one entry per
// cycle), an add then shifts the tail of the memory up or down one entry per
// cycle, and a final pass sums the counts. A zero-count add, a rejected add,
// a clear and a next-lower at zero skip the first pass. The result is shown
// on the rsp_ ports for a single cycle marked by rsp_valid, and the receiver
// cannot stall it.
module uid_interval_set import uis_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_first_uid,
   input  logic [31:0] req_uid_count,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic        rsp_covered,
   output logic        rsp_overlapping,
   output logic [31:0] rsp_found_uid,
   output logic [31:0] rsp_total_ids,
   output logic [31:0] rsp_lowest_uid,
   output logic        rsp_set_empty,
   output logic [6:0]  rsp_stored_entries
);
   logic [63:0] mem [MaxEntries];
   logic [63:0] rd_data;
   logic [IdxW-1:0] rd_addr, wr_addr;
   logic [63:0] wr_data;
   logic wr_en;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

   state_type state_ff, state_in;
   op_type op_ff, op_in;
   logic [31:0] a_ff, a_in, n_ff, n_in;
   logic [CntW-1:0] total_ff, total_in;
   logic [CntW-1:0] ptr_ff, ptr_in;      // issued read index
   logic [CntW-1:0] idx_ff, idx_in;      // index of rd_data
   logic rv_ff, rv_in;                   // rd_data valid
   logic [CntW-1:0] i_ff, i_in, j_ff, j_in;
   logic have_i_ff, have_i_in;
   logic [32:0] lo_ff, lo_in, hi_ff, hi_in;
   logic cov_ff, cov_in, ovl_ff, ovl_in, have_ff, have_in, hit_ff, hit_in;
   logic [31:0] found_ff, found_in, sum_ff, sum_in, low_ff, low_in;
   logic [1:0] st_ff, st_in;
   logic [CntW-1:0] newtot_ff, newtot_in;
   logic [CntW-1:0] mv_ff, mv_in;
   logic mvdn_ff, mvdn_in;

   logic [31:0] e_start, e_count, e_last;
   logic [32:0] e_end, q_end, q_cl;
   logic [31:0] cand;

   assign e_start = rd_data[63:32];
   assign e_count = rd_data[31:0];
   assign e_end = {1'b0, e_start} + {1'b0, e_count};
   assign e_last = e_start + e_count - 32'd1;
   assign cand = a_ff - 32'd1;
   assign q_end = {1'b0, a_ff} + {1'b0, n_ff};
   assign q_cl = q_end[32] ? {1'b0, UidAllOnes} : q_end;

   always_comb begin
      state_in = state_ff; op_in = op_ff; a_in = a_ff; n_in = n_ff;
      total_in = total_ff; ptr_in = ptr_ff; idx_in = idx_ff; rv_in = 1'b0;
      i_in = i_ff; j_in = j_ff; have_i_in = have_i_ff; lo_in = lo_ff; hi_in = hi_ff;
      cov_in = cov_ff; ovl_in = ovl_ff; have_in = have_ff; hit_in = hit_ff;
      found_in = found_ff; sum_in = sum_ff; low_in = low_ff; st_in = st_ff;
      newtot_in = newtot_ff; mv_in = mv_ff; mvdn_in = mvdn_ff;
      rd_addr = ptr_ff[IdxW-1:0]; wr_en = 1'b0; wr_addr = '0; wr_data = '0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in = op_type'(req_opcode); a_in = req_first_uid; n_in = req_uid_count;
               cov_in = 1'b0; ovl_in = 1'b0; have_in = 1'b0; hit_in = 1'b0;
               found_in = '0; st_in = ST_OK; have_i_in = 1'b0;
               lo_in = {1'b0, req_first_uid};
               hi_in = {1'b0, req_first_uid} + {1'b0, req_uid_count};
               ptr_in = '0; i_in = total_ff; j_in = total_ff;
               state_in = S_SCAN;
               case (op_type'(req_opcode))
                  OP_ADD: begin
                     if (req_uid_count == '0) state_in = S_SUM;
                     else if ({1'b0, req_first_uid} + {1'b0, req_uid_count} > 33'h0FFFFFFFF) begin
                        st_in = ST_RANGE; state_in = S_SUM;
                     end else if (total_ff >= CntW'(MaxEntries)) begin
                        st_in = ST_FULL; state_in = S_SUM;
                     end
                  end
                  OP_QUERY: cov_in = (req_uid_count == '0);
                  OP_LOWER: if (req_first_uid == '0) begin
                     st_in = ST_NO_LOWER; state_in = S_SUM;
                  end
                  default: begin
                     total_in = '0; state_in = S_SUM;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (ptr_ff < total_ff) begin
               rv_in = 1'b1; idx_in = ptr_ff; ptr_in = ptr_ff + 1'b1;
            end
            if (rv_ff) begin
               case (op_ff)
                  OP_ADD: begin
                     if (!have_i_ff && e_end >= lo_ff) begin
                        have_i_in = 1'b1; i_in = idx_ff;
                     end
                     if ((have_i_ff || e_end >= lo_ff) && j_ff == total_ff) begin
                        if ({1'b0, e_start} <= hi_ff) begin
                           if ({1'b0, e_start} < lo_ff) lo_in = {1'b0, e_start};
                           if (e_end > hi_ff) hi_in = e_end;
                        end else j_in = idx_ff;
                     end
                  end
                  OP_QUERY: begin
                     if (!q_end[32] && n_ff != '0 && a_ff >= e_start && q_end <= e_end)
                        cov_in = 1'b1;
                     if (q_cl != {1'b0, a_ff} && {1'b0, a_ff} < e_end && q_cl >= {1'b0, e_start})
                        ovl_in = 1'b1;
                  end
                  default: begin
                     if (!hit_ff) begin
                        if (cand >= e_start && cand <= e_last) begin
                           hit_in = 1'b1; found_in = cand;
                        end else if (e_last < cand) begin
                           have_in = 1'b1; found_in = e_last;
                        end
                     end
                  end
               endcase
            end
            if (!(ptr_ff < total_ff) && !rv_ff) begin
               state_in = S_SUM;
               if (op_ff == OP_LOWER && !hit_ff && !have_ff) st_in = ST_NO_LOWER;
               if (op_ff == OP_ADD) begin
                  if (!have_i_ff) i_in = total_ff;
                  // merged entries [i, j); j already total if none beyond
                  if (!have_i_ff || j_ff == i_ff) begin
                     // insert: shift [i,total) up by one, from the top
                     newtot_in = total_ff + 1'b1;
                     mvdn_in = 1'b0; mv_in = total_ff;
                     state_in = S_MOVE;
                  end else begin
                     newtot_in = total_ff - (j_ff - i_ff) + 1'b1;
                     mvdn_in = 1'b1; mv_in = j_ff;
                     state_in = S_MOVE;
                  end
               end
            end
         end
         S_MOVE: begin
            // read source, write next cycle
            if (!mvdn_ff) begin
               if (rv_ff) begin
                  wr_en = 1'b1; wr_addr = IdxW'(idx_ff + 1'b1); wr_data = rd_data;
               end
               if (mv_ff > i_ff) begin
                  rd_addr = IdxW'(mv_ff - 1'b1); rv_in = 1'b1;
                  idx_in = mv_ff - 1'b1; mv_in = mv_ff - 1'b1;
               end else if (!rv_ff) state_in = S_WRITE;
            end else begin
               if (rv_ff) begin
                  wr_en = 1'b1; wr_addr = IdxW'(idx_ff - (j_ff - i_ff) + 1'b1);
                  wr_data = rd_data;
               end
               if (mv_ff < total_ff) begin
                  rd_addr = IdxW'(mv_ff); rv_in = 1'b1;
                  idx_in = mv_ff; mv_in = mv_ff + 1'b1;
               end else if (!rv_ff) state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            wr_en = 1'b1; wr_addr = IdxW'(i_ff);
            wr_data = {lo_ff[31:0], 32'(hi_ff - lo_ff)};
            total_in = newtot_ff; state_in = S_SUM;
         end
         S_SUM: begin
            ptr_in = '0; sum_in = '0; low_in = UidAllOnes;
            state_in = S_DONE;
         end
         default: begin
            if (ptr_ff < total_ff) begin
               rv_in = 1'b1; idx_in = ptr_ff; ptr_in = ptr_ff + 1'b1;
            end
            if (rv_ff) begin
               sum_in = sum_ff + e_count;
               if (idx_ff == '0) low_in = e_start;
            end
            if (!(ptr_ff < total_ff) && !rv_ff) begin
               rsp_valid = 1'b1; state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; total_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; total_ff <= total_in; rv_ff <= rv_in;
      end
      op_ff <= op_in; a_ff <= a_in; n_ff <= n_in; ptr_ff <= ptr_in; idx_ff <= idx_in;
      i_ff <= i_in; j_ff <= j_in; have_i_ff <= have_i_in; lo_ff <= lo_in; hi_ff <= hi_in;
      cov_ff <= cov_in; ovl_ff <= ovl_in; have_ff <= have_in; hit_ff <= hit_in;
      found_ff <= found_in; sum_ff <= sum_in; low_ff <= low_in; st_ff <= st_in;
      newtot_ff <= newtot_in; mv_ff <= mv_in; mvdn_ff <= mvdn_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_status = st_ff;
   assign rsp_covered = cov_ff;
   assign rsp_overlapping = ovl_ff;
   assign rsp_found_uid = found_ff;
   assign rsp_total_ids = sum_ff;
   assign rsp_lowest_uid = low_ff;
   assign rsp_set_empty = (total_ff == '0);
   assign rsp_stored_entries = 7'(total_ff);

`ifndef SYNTH
   a_cap: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CntW'(MaxEntries)) else $error("entry count beyond capacity");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after result");
   a_wr_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> busy) else $error("write while idle");
   a_grow: assert property (@(posedge clock) disable iff (reset)
      (!busy && !$past(busy)) |-> $stable(total_ff)) else $error("count moved while idle");
`endif
endmodule
